// ----- rtl/bls_pkg.sv -----
`default_nettype none

package bls_pkg;

   // Operation codes carried in the operation field of a request word.
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Depth of the command queue between the front and the back end.
   localparam int unsigned QUEUE_DEPTH = 4;

   // Status reported by the back end to the top level.
   typedef struct packed {
      logic line_active;
      logic pixels_zero;
      logic pop;
      logic out_load;
   } back_status_type;

endpackage

`default_nettype wire

// ----- rtl/bls_front.sv -----
`default_nettype none

module bls_front #(
   parameter int unsigned CB = 12,
   parameter int unsigned EW = 4 * CB + 4
) (
   input  wire logic          operation,
   input  wire logic [CB-1:0] start_x,
   input  wire logic [CB-1:0] start_y,
   input  wire logic [CB-1:0] end_x,
   input  wire logic [CB-1:0] end_y,
   output logic      [EW-1:0] entry
);
   import bls_pkg::*;

   logic [CB-1:0] dx;
   logic [CB-1:0] dy;
   logic          x_down;
   logic          y_down;
   logic          steep;
   logic [CB-1:0] major;
   logic [CB-1:0] minor;

   // Absolute deltas, directions and the major axis of a new line.
   always_comb begin
      x_down = (end_x < start_x);
      y_down = (end_y < start_y);
      dx     = x_down ? (start_x - end_x) : (end_x - start_x);
      dy     = y_down ? (start_y - end_y) : (end_y - start_y);
      steep  = (dy > dx);
      major  = steep ? dy : dx;
      minor  = steep ? dx : dy;
      entry  = {operation, start_x, start_y, major, minor, y_down, x_down, steep};
   end

endmodule

`default_nettype wire

// ----- rtl/bls_queue.sv -----
`default_nettype none

module bls_queue #(
   parameter int unsigned EW = 52
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire logic [EW-1:0] push_data,
   output logic               full,
   input  wire logic          pop,
   output logic               not_empty,
   output logic      [EW-1:0] head_data
);
   import bls_pkg::*;

   localparam int unsigned AW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   logic [EW-1:0] slot_ff [QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bls_back.sv -----
`default_nettype none

module bls_back #(
   parameter int unsigned CB = 12,
   parameter int unsigned EW = 4 * CB + 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   input  wire logic [EW-1:0]            q_data,
   output logic                          q_pop,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [CB-1:0]                 out_x,
   output logic [CB-1:0]                 out_y,
   output logic                          out_last,
   output bls_pkg::back_status_type      status
);
   import bls_pkg::*;

   localparam int unsigned DW = CB + 3;

   logic          e_op;
   logic [CB-1:0] e_sx, e_sy, e_major, e_minor;
   logic          e_ydown, e_xdown, e_steep;

   logic                 active_ff, active_in;
   logic [CB-1:0]        cur_x_ff, cur_x_in;
   logic [CB-1:0]        cur_y_ff, cur_y_in;
   logic signed [DW-1:0] dec_ff, dec_in;
   logic signed [DW-1:0] inc_pos_ff, inc_pos_in;
   logic signed [DW-1:0] inc_neg_ff, inc_neg_in;
   logic [CB:0]          left_ff, left_in;
   logic                 xdown_ff, xdown_in;
   logic                 ydown_ff, ydown_in;
   logic                 steep_ff, steep_in;
   logic                 ovalid_ff, ovalid_in;
   logic [CB-1:0]        ox_ff, ox_in;
   logic [CB-1:0]        oy_ff, oy_in;
   logic                 olast_ff, olast_in;

   logic out_free;
   logic emit;
   logic minor_move;
   logic [CB-1:0] x_next, y_next;

   assign {e_op, e_sx, e_sy, e_major, e_minor, e_ydown, e_xdown, e_steep} = q_data;

   assign out_free = !ovalid_ff || out_ready;
   assign q_pop    = q_valid && out_free;
   assign emit     = q_pop && (e_op == OP_STEP) && active_ff;

   always_comb begin
      minor_move = !dec_ff[DW-1];
      x_next = xdown_ff ? cur_x_ff - CB'(1) : cur_x_ff + CB'(1);
      y_next = ydown_ff ? cur_y_ff - CB'(1) : cur_y_ff + CB'(1);

      active_in  = active_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      dec_in     = dec_ff;
      inc_pos_in = inc_pos_ff;
      inc_neg_in = inc_neg_ff;
      left_in    = left_ff;
      xdown_in   = xdown_ff;
      ydown_in   = ydown_ff;
      steep_in   = steep_ff;
      ox_in      = ox_ff;
      oy_in      = oy_ff;
      olast_in   = olast_ff;
      ovalid_in  = emit ? 1'b1 : (out_ready ? 1'b0 : ovalid_ff);

      if (q_pop && (e_op == OP_START)) begin
         active_in  = 1'b1;
         cur_x_in   = e_sx;
         cur_y_in   = e_sy;
         inc_pos_in = signed'({2'b00, e_minor, 1'b0});
         inc_neg_in = signed'({2'b00, e_minor, 1'b0}) - signed'({2'b00, e_major, 1'b0});
         dec_in     = signed'({2'b00, e_minor, 1'b0}) - signed'({3'b000, e_major});
         left_in    = {1'b0, e_major} + (CB + 1)'(1);
         xdown_in   = e_xdown;
         ydown_in   = e_ydown;
         steep_in   = e_steep;
      end else if (emit) begin
         ox_in    = cur_x_ff;
         oy_in    = cur_y_ff;
         olast_in = (left_ff == (CB + 1)'(1));
         if (steep_ff) begin
            cur_y_in = y_next;
            if (minor_move) begin
               cur_x_in = x_next;
            end
         end else begin
            cur_x_in = x_next;
            if (minor_move) begin
               cur_y_in = y_next;
            end
         end
         dec_in    = dec_ff + (minor_move ? inc_neg_ff : inc_pos_ff);
         left_in   = left_ff - (CB + 1)'(1);
         active_in = (left_ff != (CB + 1)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         ovalid_ff  <= 1'b0;
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         dec_ff     <= '0;
         inc_pos_ff <= '0;
         inc_neg_ff <= '0;
         left_ff    <= '0;
         xdown_ff   <= 1'b0;
         ydown_ff   <= 1'b0;
         steep_ff   <= 1'b0;
      end else begin
         active_ff  <= active_in;
         ovalid_ff  <= ovalid_in;
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         dec_ff     <= dec_in;
         inc_pos_ff <= inc_pos_in;
         inc_neg_ff <= inc_neg_in;
         left_ff    <= left_in;
         xdown_ff   <= xdown_in;
         ydown_ff   <= ydown_in;
         steep_ff   <= steep_in;
      end
   end

   always_ff @(posedge clock) begin
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      olast_ff <= olast_in;
   end

   assign out_valid = ovalid_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;
   assign out_last  = olast_ff;

   always_comb begin
      status.line_active = active_ff;
      status.pixels_zero = (left_ff == '0);
      status.pop         = q_pop;
      status.out_load    = emit;
   end

endmodule

`default_nettype wire

// ----- rtl/bresenham_line_stepper.sv -----
// A step word is queued, then loaded into the output register that drives rsp_.
// Throughput: one word per cycle, one pixel per cycle while rsp_ready stays high.
// The rate is set by the back end's single add on the decision term per pixel.
// A start word produces no pixel; the back end loads the line from it.
// Reset is synchronous and active high; it empties the queue and leaves the block idle.
`default_nettype none

module bresenham_line_stepper #(
   parameter int unsigned COORD_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_operation,
   input  wire logic [COORD_BITS-1:0] req_start_x,
   input  wire logic [COORD_BITS-1:0] req_start_y,
   input  wire logic [COORD_BITS-1:0] req_end_x,
   input  wire logic [COORD_BITS-1:0] req_end_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [COORD_BITS-1:0]      rsp_pixel_x,
   output logic [COORD_BITS-1:0]      rsp_pixel_y,
   output logic                       rsp_last_pixel
);
   import bls_pkg::*;

   // A queue entry holds the operation, the start point, both deltas, the
   // two direction bits and the steep flag.
   localparam int unsigned EW = 4 * COORD_BITS + 4;

   logic            q_full;
   logic            q_not_empty;
   logic            q_pop;
   logic [EW-1:0]   front_entry;
   logic [EW-1:0]   head_entry;
   back_status_type status;

   // The front end classifies each word and, for a start word, works out the
   // absolute deltas, the step directions and which axis is the major one.
   bls_front #(
      .CB (COORD_BITS),
      .EW (EW)
   ) u_front (
      .operation (req_operation),
      .start_x   (req_start_x),
      .start_y   (req_start_y),
      .end_x     (req_end_x),
      .end_y     (req_end_y),
      .entry     (front_entry)
   );

   // The queue decouples the request side from the pixel side, so a stalled
   // result channel does not stop new words from being taken until it fills.
   assign req_ready = !q_full;

   bls_queue #(
      .EW (EW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && req_ready),
      .push_data (front_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (head_entry)
   );

   // The back end holds the line state and steps one pixel per step command into
   // an output register; a step that arrives with no line in progress is
   // dropped without a result.
   bls_back #(
      .CB (COORD_BITS),
      .EW (EW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_data    (head_entry),
      .q_pop     (q_pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_x     (rsp_pixel_x),
      .out_y     (rsp_pixel_y),
      .out_last  (rsp_last_pixel),
      .status    (status)
   );

   // An active line always has at least one pixel left to give.
   a_active_has_pixels: assert property (@(posedge clock) disable iff (reset)
      status.line_active |-> !status.pixels_zero)
      else $error("line active with no pixels left");

   // The back end only takes commands the queue actually holds.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      status.pop |-> q_not_empty)
      else $error("queue popped while empty");

   // Once the final pixel of a line is loaded for output, the line is over.
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      status.out_load |=> (!rsp_last_pixel || !status.line_active))
      else $error("line still active after its last pixel");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none

// Self-checking bench for the Bresenham line stepper.
// A directed table runs first. It covers the idle block after reset, a single-point
// line, the corner-to-corner diagonal, a steep line that replaces an active one, and
// a short line with x falling from the top of the range. Random lines follow. Most
// of them are short and stepped to their last pixel. Some are long and cut short
// by a new start word. A few are dropped right after they load, and steps that
// reach an idle block are mixed in. Every accepted request word runs through a
// predictor that keeps its own copy of the line state. Every accepted pixel is
// checked against the oldest prediction.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bls_pkg::*;

   localparam int CB            = 12;
   localparam int MAXC          = (1 << CB) - 1;
   localparam int RANDOM_WORDS  = 450;
   localparam int CALM_WORDS    = 60;    // the last words of the run go without idling
   localparam int HOLD_CYCLES   = 120;   // the one long hold-off of the pixel receiver
   localparam int DRAIN_CYCLES  = 10;
   localparam int WATCHDOG_LIMIT = 2000;

   // A stimulus row. The expectation fields count only when known is set. Then the
   // pixel, or the absence of one, is the one the row itself gives.
   typedef struct packed {
      logic          op;
      logic [CB-1:0] sx;
      logic [CB-1:0] sy;
      logic [CB-1:0] ex;
      logic [CB-1:0] ey;
      logic          known;
      logic          has_pixel;
      logic [CB-1:0] px;
      logic [CB-1:0] py;
      logic          last;
   } stim_row_type;

   typedef struct packed {
      logic [CB-1:0] x;
      logic [CB-1:0] y;
      logic          last;
   } pixel_type;

   logic          clock          = 1'b0;
   logic          reset          = 1'b1;
   logic          req_valid      = 1'b0;
   logic          req_ready;
   logic          req_operation  = OP_START;
   logic [CB-1:0] req_start_x    = '0;
   logic [CB-1:0] req_start_y    = '0;
   logic [CB-1:0] req_end_x      = '0;
   logic [CB-1:0] req_end_y      = '0;
   logic          rsp_valid;
   logic          rsp_ready      = 1'b0;
   logic [CB-1:0] rsp_pixel_x;
   logic [CB-1:0] rsp_pixel_y;
   logic          rsp_last_pixel;

   // This row goes out with the word on the request port. The scoreboard samples it
   // together with that word.
   stim_row_type  word_row       = '0;

   always #1 clock = ~clock;

   bresenham_line_stepper #(.COORD_BITS(CB)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

   // ---------------------------------------------------------------------------------
   // Line predictor. It keeps its own copy of the line state and traces one word.
   // ---------------------------------------------------------------------------------
   logic [CB-1:0]        ln_x, ln_y;
   logic [CB-1:0]        ln_major, ln_minor;
   logic signed [CB+2:0] ln_err;
   logic [CB:0]          ln_left;
   logic                 ln_x_down, ln_y_down, ln_steep, ln_active;

   pixel_type pixels_due[$];
   int        mismatches     = 0;
   int        pixels_checked = 0;

   // Flags for the processes that drive the two sides.
   bit     final_stretch  = 0;
   bit     holding        = 0;
   bit     gappy          = 0;

   function automatic void clear_line();
      ln_x      = '0;
      ln_y      = '0;
      ln_major  = '0;
      ln_minor  = '0;
      ln_err    = '0;
      ln_left   = '0;
      ln_x_down = 1'b0;
      ln_y_down = 1'b0;
      ln_steep  = 1'b0;
      ln_active = 1'b0;
   endfunction

   // Returns 1 when the word yields a pixel, which then comes back in px.
   function automatic bit trace_word(input stim_row_type w, output pixel_type px);
      logic [CB-1:0] dx, dy;
      bit            minor_move;
      px = '0;
      if (w.op == OP_START) begin
         dx        = (w.ex >= w.sx) ? w.ex - w.sx : w.sx - w.ex;
         dy        = (w.ey >= w.sy) ? w.ey - w.sy : w.sy - w.ey;
         ln_x_down = w.ex < w.sx;
         ln_y_down = w.ey < w.sy;
         // When the deltas are equal, x stays the major axis.
         ln_steep  = dy > dx;
         ln_major  = ln_steep ? dy : dx;
         ln_minor  = ln_steep ? dx : dy;
         ln_err    = (CB + 3)'(2 * int'(ln_minor) - int'(ln_major));
         ln_left   = {1'b0, ln_major} + 1'b1;
         ln_x      = w.sx;
         ln_y      = w.sy;
         ln_active = 1'b1;
         return 0;
      end
      // A step that reaches an idle block is dropped without a pixel.
      if (!ln_active)
         return 0;
      px.x       = ln_x;
      px.y       = ln_y;
      px.last    = ln_left == 1;
      minor_move = ln_err >= 0;
      // Coordinates wrap at the field width. Past the last pixel this changes only
      // state that is never shown.
      if (ln_steep) begin
         ln_y = ln_y_down ? ln_y - 1'b1 : ln_y + 1'b1;
         if (minor_move)
            ln_x = ln_x_down ? ln_x - 1'b1 : ln_x + 1'b1;
      end else begin
         ln_x = ln_x_down ? ln_x - 1'b1 : ln_x + 1'b1;
         if (minor_move)
            ln_y = ln_y_down ? ln_y - 1'b1 : ln_y + 1'b1;
      end
      ln_err  = (CB + 3)'(int'(ln_err) + 2 * int'(ln_minor) -
                          (minor_move ? 2 * int'(ln_major) : 0));
      ln_left = ln_left - 1'b1;
      if (ln_left == 0)
         ln_active = 1'b0;
      return 1;
   endfunction

   // ---------------------------------------------------------------------------------
   // Scoreboard. At each rising edge it sees the values from just before the edge.
   // It predicts first for an accepted request word, then checks an accepted pixel.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      pixel_type predicted;
      pixel_type want;
      bit        produced;
      if (reset) begin
         clear_line();
         pixels_due.delete();
      end else begin
         if (req_valid && req_ready) begin
            produced = trace_word(word_row, predicted);
            if (word_row.known) begin
               if (word_row.has_pixel)
                  pixels_due.push_back('{word_row.px, word_row.py, word_row.last});
            end else if (produced) begin
               pixels_due.push_back(predicted);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pixels_due.size() == 0) begin
               mismatches++;
               $display("%0t: pixel with none expected: x=%0d y=%0d last=%0b",
                        $time, rsp_pixel_x, rsp_pixel_y, rsp_last_pixel);
            end else begin
               want = pixels_due.pop_front();
               pixels_checked++;
               if (rsp_pixel_x !== want.x) begin
                  mismatches++;
                  $display("%0t: pixel_x expected %0d, got %0d",
                           $time, want.x, rsp_pixel_x);
               end
               if (rsp_pixel_y !== want.y) begin
                  mismatches++;
                  $display("%0t: pixel_y expected %0d, got %0d",
                           $time, want.y, rsp_pixel_y);
               end
               if (rsp_last_pixel !== want.last) begin
                  mismatches++;
                  $display("%0t: last_pixel expected %0b, got %0b",
                           $time, want.last, rsp_last_pixel);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Watchdog. The run ends when nothing moves on either port for too long.
   // ---------------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word accepted for %0d cycles", $time, quiet_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Pixel receiver. It stalls in random bursts, in stretches that either allow
   // stalls or not. Once, after 40 pixels, it holds off for a long time so that the
   // block fills up and drops req_ready. In the final stretch it is always ready.
   // ---------------------------------------------------------------------------------
   initial begin : receiver
      int  cycle_no;
      bit  stall_mode;
      bit  held_once;
      cycle_no   = 0;
      stall_mode = 0;
      held_once  = 0;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (cycle_no % 64 == 0)
            stall_mode = $urandom_range(0, 2) != 0;
         if (!reset && !held_once && pixels_checked >= 40) begin
            held_once = 1;
            holding   = 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            holding   = 0;
         end else if (!reset && !final_stretch && stall_mode &&
                      $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Request sender.
   // ---------------------------------------------------------------------------------
   function automatic stim_row_type word(input logic op, input int sx, sy, ex, ey);
      word    = '0;
      word.op = op;
      word.sx = sx[CB-1:0];
      word.sy = sy[CB-1:0];
      word.ex = ex[CB-1:0];
      word.ey = ey[CB-1:0];
   endfunction

   // The same word, with its result written into the row by hand.
   function automatic stim_row_type known(input stim_row_type w, input bit has_pixel,
                                          input int px, py, input bit last);
      known           = w;
      known.known     = 1'b1;
      known.has_pixel = has_pixel;
      known.px        = px[CB-1:0];
      known.py        = py[CB-1:0];
      known.last      = last;
   endfunction

   // A random step word. Its coordinate fields carry noise that the block ignores.
   function automatic stim_row_type step_word();
      return word(OP_STEP, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // An endpoint at most 15 away from c. It is folded back when it would leave the
   // coordinate range.
   function automatic int near_coord(input int c);
      int d, t;
      d = $urandom_range(0, 15);
      t = $urandom_range(0, 1) ? c + d : c - d;
      if (t < 0 || t > MAXC)
         t = 2 * c - t;
      return t;
   endfunction

   // Puts one word on the request port and returns at the edge that accepts it.
   // Valid stays high after the accepting edge. The next call either changes the
   // payload in place or lowers valid for a gap. So valid never gets two
   // assignments in one time step.
   task automatic send_word(input stim_row_type w);
      if (!final_stretch && !holding && gappy && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= w.op;
      req_start_x   <= w.sx;
      req_start_y   <= w.sy;
      req_end_x     <= w.ex;
      req_end_y     <= w.ey;
      word_row      <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin : stimulus
      stim_row_type directed_rows[$];
      int           counted_words;
      int           shape;
      int           sx, sy, ex, ey;
      int           major, steps;

      // Directed table. Rows with a result written in are the obvious ones: the idle
      // block after reset, the single-point line, the corner of the full diagonal and
      // the step after the steep line ends. The predictor checks the others.
      directed_rows.push_back(known(word(OP_STEP, MAXC, MAXC, MAXC, MAXC), 0, 0, 0, 0));
      directed_rows.push_back(known(word(OP_START, 0, 0, 0, 0), 0, 0, 0, 0));
      directed_rows.push_back(known(word(OP_STEP, 0, 0, 0, 0), 1, 0, 0, 1));
      directed_rows.push_back(known(word(OP_STEP, 0, 0, 0, 0), 0, 0, 0, 0));
      // Full diagonal from the top corner down to the origin. The deltas are equal,
      // so x is the major axis.
      directed_rows.push_back(known(word(OP_START, MAXC, MAXC, 0, 0), 0, 0, 0, 0));
      directed_rows.push_back(known(word(OP_STEP, 0, 0, 0, 0), 1, MAXC, MAXC, 0));
      directed_rows.push_back(word(OP_STEP, 0, 0, 0, 0));
      // A steep line with x rising and y falling replaces the diagonal in mid-line.
      directed_rows.push_back(word(OP_START, 0, MAXC, 3, MAXC - 9));
      repeat (10) directed_rows.push_back(step_word());
      directed_rows.push_back(known(word(OP_STEP, 0, 0, 0, 0), 0, 0, 0, 0));
      // A short line with x falling from the top of the range.
      directed_rows.push_back(word(OP_START, MAXC, 0, MAXC - 1, 0));
      directed_rows.push_back(step_word());
      directed_rows.push_back(step_word());
      // Alternating bit patterns across all four endpoint fields.
      directed_rows.push_back(word(OP_START, 12'hAAA, 12'h555, 12'h555, 12'hAAA));
      directed_rows.push_back(step_word());
      directed_rows.push_back(step_word());

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      gappy = 1;
      foreach (directed_rows[i])
         send_word(directed_rows[i]);

      // Random lines. Most are short and stepped to their last pixel. Some are long
      // and cut short by the next start. A few are dropped at once. Steps sent to an
      // idle block are not counted as stimulus.
      counted_words = 0;
      while (counted_words < RANDOM_WORDS) begin
         shape = $urandom_range(0, 19);
         gappy = $urandom_range(0, 2) != 0;
         sx    = $urandom_range(0, MAXC);
         sy    = $urandom_range(0, MAXC);
         if (shape < 15) begin
            ex = near_coord(sx);
            ey = near_coord(sy);
         end else begin
            ex = $urandom_range(0, MAXC);
            ey = $urandom_range(0, MAXC);
         end
         major = (ex > sx ? ex - sx : sx - ex);
         if ((ey > sy ? ey - sy : sy - ey) > major)
            major = ey > sy ? ey - sy : sy - ey;
         send_word(word(OP_START, sx, sy, ex, ey));
         counted_words++;
         if (shape != 19) begin
            steps = (shape < 15) ? major + 1 : $urandom_range(1, 24);
            if (steps > major + 1)
               steps = major + 1;
            repeat (steps) begin
               send_word(step_word());
               counted_words++;
            end
            if (steps == major + 1 && $urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 2)) send_word(step_word());
         end
         if (counted_words >= RANDOM_WORDS - CALM_WORDS)
            final_stretch = 1;
      end

      // Let the last pixels out, then give the block time to show any stray output.
      req_valid <= 1'b0;
      while (pixels_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
